FILE: hdl/qvr_pkg.sv
// Shared constants and types for the quaternion vector rotation block.
package qvr_pkg;

  // Quaternion fraction bits (Q1.14) and derived rounding shift
  localparam int FRAC_BITS  = 14;
  localparam int RND_SHIFT  = 2 * FRAC_BITS;

  // Field widths
  localparam int QUAT_W     = 16;
  localparam int VEC_W      = 16;
  localparam int ROT_W      = 16;

  // Internal widths: q*v product, first Hamilton sum, q*p product, second sum
  localparam int PROD1_W    = QUAT_W + VEC_W;
  localparam int P_W        = PROD1_W + 2;
  localparam int PROD2_W    = QUAT_W + P_W;
  localparam int R_W        = PROD2_W + 2;
  localparam int SH_W       = R_W - RND_SHIFT;

  // Output clip limits
  localparam int OUT_MAX    = (1 << (ROT_W - 1)) - 1;
  localparam int OUT_MIN    = -(1 << (ROT_W - 1));

  // Pipeline depth
  localparam int NUM_STAGES = 5;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_W = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_Y = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_Z = 2'd3;

  typedef struct packed {
    logic signed [QUAT_W-1:0] w;
    logic signed [QUAT_W-1:0] x;
    logic signed [QUAT_W-1:0] y;
    logic signed [QUAT_W-1:0] z;
  } quat_t;

  // Per-stage load enables from the handshake logic
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } pipe_ctrl_t;

endpackage

FILE: hdl/qvr_datapath.sv
// Five-stage arithmetic pipeline: q*(0,v), then *conj(q), round and clip.
module qvr_datapath import qvr_pkg::*; (
  input  logic                    clk,
  input  pipe_ctrl_t              ctrl,
  input  quat_t                   quat,
  input  logic signed [VEC_W-1:0] vec_x,
  input  logic signed [VEC_W-1:0] vec_y,
  input  logic signed [VEC_W-1:0] vec_z,
  output logic signed [ROT_W-1:0] rot_x,
  output logic signed [ROT_W-1:0] rot_y,
  output logic signed [ROT_W-1:0] rot_z,
  output logic                    saturated
);

  localparam logic signed [R_W-1:0]  RND_HALF = R_W'(1) <<< (RND_SHIFT - 1);
  localparam logic signed [SH_W-1:0] LIM_HI   = SH_W'(OUT_MAX);
  localparam logic signed [SH_W-1:0] LIM_LO   = SH_W'(OUT_MIN);

  // Stage 0 registers: the twelve q*v products
  logic signed [PROD1_W-1:0] m1 [12];
  // Stage 1 registers: p = q * (0,v)
  logic signed [P_W-1:0]     pw, px, py, pz;
  // Stage 2 registers: the twelve q*p products
  logic signed [PROD2_W-1:0] m2 [12];
  // Stage 3 registers: vector part of p * conj(q)
  logic signed [R_W-1:0]     r [3];

  logic signed [R_W-1:0]     r_rnd [3];
  logic signed [SH_W-1:0]    r_sh  [3];
  logic signed [ROT_W-1:0]   r_clip [3];
  logic [2:0]                r_hit;

  // Stage 0: multiply quaternion by vector components
  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      m1[0]  <= PROD1_W'(quat.x) * PROD1_W'(vec_x);
      m1[1]  <= PROD1_W'(quat.y) * PROD1_W'(vec_y);
      m1[2]  <= PROD1_W'(quat.z) * PROD1_W'(vec_z);
      m1[3]  <= PROD1_W'(quat.w) * PROD1_W'(vec_x);
      m1[4]  <= PROD1_W'(quat.y) * PROD1_W'(vec_z);
      m1[5]  <= PROD1_W'(quat.z) * PROD1_W'(vec_y);
      m1[6]  <= PROD1_W'(quat.w) * PROD1_W'(vec_y);
      m1[7]  <= PROD1_W'(quat.z) * PROD1_W'(vec_x);
      m1[8]  <= PROD1_W'(quat.x) * PROD1_W'(vec_z);
      m1[9]  <= PROD1_W'(quat.w) * PROD1_W'(vec_z);
      m1[10] <= PROD1_W'(quat.x) * PROD1_W'(vec_y);
      m1[11] <= PROD1_W'(quat.y) * PROD1_W'(vec_x);
    end
  end

  // Stage 1: dot product for the scalar part, scaled sums plus cross product
  always_ff @(posedge clk) begin
    if (ctrl.load[1]) begin
      pw <= -(P_W'(m1[0]) + P_W'(m1[1]) + P_W'(m1[2]));
      px <= P_W'(m1[3]) + P_W'(m1[4]) - P_W'(m1[5]);
      py <= P_W'(m1[6]) + P_W'(m1[7]) - P_W'(m1[8]);
      pz <= P_W'(m1[9]) + P_W'(m1[10]) - P_W'(m1[11]);
    end
  end

  // Stage 2: multiply p by quaternion components
  always_ff @(posedge clk) begin
    if (ctrl.load[2]) begin
      m2[0]  <= PROD2_W'(quat.x) * PROD2_W'(pw);
      m2[1]  <= PROD2_W'(quat.w) * PROD2_W'(px);
      m2[2]  <= PROD2_W'(quat.z) * PROD2_W'(py);
      m2[3]  <= PROD2_W'(quat.y) * PROD2_W'(pz);
      m2[4]  <= PROD2_W'(quat.y) * PROD2_W'(pw);
      m2[5]  <= PROD2_W'(quat.w) * PROD2_W'(py);
      m2[6]  <= PROD2_W'(quat.x) * PROD2_W'(pz);
      m2[7]  <= PROD2_W'(quat.z) * PROD2_W'(px);
      m2[8]  <= PROD2_W'(quat.z) * PROD2_W'(pw);
      m2[9]  <= PROD2_W'(quat.w) * PROD2_W'(pz);
      m2[10] <= PROD2_W'(quat.y) * PROD2_W'(px);
      m2[11] <= PROD2_W'(quat.x) * PROD2_W'(py);
    end
  end

  // Stage 3: r = -qv*pw + w*pv - cross(pv, qv)
  always_ff @(posedge clk) begin
    if (ctrl.load[3]) begin
      for (int i = 0; i < 3; i++) begin
        r[i] <= -R_W'(m2[4*i]) + R_W'(m2[4*i+1]) - R_W'(m2[4*i+2]) + R_W'(m2[4*i+3]);
      end
    end
  end

  // Round half up, shift out the fraction, clip to the output range
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r_rnd[i] = r[i] + RND_HALF;
      r_sh[i]  = r_rnd[i][R_W-1:RND_SHIFT];
      if (r_sh[i] > LIM_HI) begin
        r_clip[i] = ROT_W'(OUT_MAX);
        r_hit[i]  = 1'b1;
      end else if (r_sh[i] < LIM_LO) begin
        r_clip[i] = ROT_W'(OUT_MIN);
        r_hit[i]  = 1'b1;
      end else begin
        r_clip[i] = r_sh[i][ROT_W-1:0];
        r_hit[i]  = 1'b0;
      end
    end
  end

  // Stage 4: output register
  always_ff @(posedge clk) begin
    if (ctrl.load[4]) begin
      rot_x     <= r_clip[0];
      rot_y     <= r_clip[1];
      rot_z     <= r_clip[2];
      saturated <= |r_hit;
    end
  end

endmodule

FILE: hdl/quaternion_vector_rotate_top.sv
// Top level of the quaternion vector rotation block: config, handshake, pipeline.
//
// Rotates each input vector (vec_x, vec_y, vec_z) by the quaternion held in
// the four configuration registers (quat_w, quat_x, quat_y, quat_z, Q1.14),
// computing the vector part of q*(0,v)*conj(q) in fixed point.
// Input channel: in_valid/in_ready, one vector per beat.
// Output channel: out_valid/out_ready, one rotated vector per beat, rounded
// to nearest and clipped to 16 bits; saturated flags any clipped component.
// Config port: cfg_we writes cfg_wdata into register cfg_index; write it only
// while no beat is in flight.
// Pipeline: an accepted input beat passes five register stages (products,
// first Hamilton sum, products, second sum, round/clip) before out_valid rises.
// Throughput: one beat per cycle while the output is not stalled, set by the
// fully pipelined multipliers.
// Reset: rst empties the pipeline and loads the identity quaternion.
// Stall: each stage holds while the one after it is full and not moving, so
// bubbles are squeezed out and in_ready drops only once all five are full.
module quaternion_vector_rotate_top import qvr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [QUAT_W-1:0]       cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [VEC_W-1:0] vec_x,
  input  logic signed [VEC_W-1:0] vec_y,
  input  logic signed [VEC_W-1:0] vec_z,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [ROT_W-1:0] rot_x,
  output logic signed [ROT_W-1:0] rot_y,
  output logic signed [ROT_W-1:0] rot_z,
  output logic                    saturated
);

  quat_t                 quat;
  pipe_ctrl_t            ctrl;
  logic [NUM_STAGES-1:0] stage_valid;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      quat.w <= QUAT_W'(1 << FRAC_BITS);
      quat.x <= '0;
      quat.y <= '0;
      quat.z <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_QUAT_W: quat.w <= cfg_wdata;
        REG_QUAT_X: quat.x <= cfg_wdata;
        REG_QUAT_Y: quat.y <= cfg_wdata;
        REG_QUAT_Z: quat.z <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Load a stage when it is empty or the stage after it advances
  always_comb begin
    ctrl.load[NUM_STAGES-1] = !stage_valid[NUM_STAGES-1] || out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      ctrl.load[k] = !stage_valid[k] || ctrl.load[k+1];
    end
  end

  // Advance valid bits alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (ctrl.load[0]) stage_valid[0] <= in_valid;
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (ctrl.load[k]) stage_valid[k] <= stage_valid[k-1];
      end
    end
  end

  assign in_ready  = ctrl.load[0];
  assign out_valid = stage_valid[NUM_STAGES-1];

  qvr_datapath u_datapath (
    .clk       (clk),
    .ctrl      (ctrl),
    .quat      (quat),
    .vec_x     (vec_x),
    .vec_y     (vec_y),
    .vec_z     (vec_z),
    .rot_x     (rot_x),
    .rot_y     (rot_y),
    .rot_z     (rot_z),
    .saturated (saturated)
  );

endmodule

FILE: hdl/qvr_checker.sv
// Port-level checks for the quaternion vector rotation top level.
module qvr_checker import qvr_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    cfg_we,
  input logic [CFG_IDX_W-1:0]    cfg_index,
  input logic [QUAT_W-1:0]       cfg_wdata,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic signed [VEC_W-1:0] vec_x,
  input logic signed [VEC_W-1:0] vec_y,
  input logic signed [VEC_W-1:0] vec_z,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [ROT_W-1:0] rot_x,
  input logic signed [ROT_W-1:0] rot_y,
  input logic signed [ROT_W-1:0] rot_z,
  input logic                    saturated
);

  // A stalled output beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(rot_x) && $stable(rot_y)
      && $stable(rot_z) && $stable(saturated))
    else $error("output beat changed while stalled");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // Input backpressure only comes from a stalled output
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output stall");

  // A clipped result has a component at a rail
  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      rot_x == ROT_W'(OUT_MAX) || rot_x == ROT_W'(OUT_MIN) ||
      rot_y == ROT_W'(OUT_MAX) || rot_y == ROT_W'(OUT_MIN) ||
      rot_z == ROT_W'(OUT_MAX) || rot_z == ROT_W'(OUT_MIN))
    else $error("saturated flag without clipped component");

endmodule

bind quaternion_vector_rotate_top qvr_checker u_qvr_checker (.*);
